// ===== rtl/bts_pkg.sv =====
package bts_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MUTE          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_HZ       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_HZ      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIFTH_LOW_HZ  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIFTH_HIGH_HZ = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SIREN_LOW_HZ  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SIREN_HIGH_HZ = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_MS       = 3'd7;

	localparam logic [2:0] SOUND_TICK  = 3'd0;
	localparam logic [2:0] SOUND_CLICK = 3'd1;
	localparam logic [2:0] SOUND_ENTER = 3'd2;
	localparam logic [2:0] SOUND_EXIT  = 3'd3;

	typedef struct packed {
		logic        opcode;
		logic [2:0]  sound_code;
		logic [31:0] now_ms;
		logic        error_siren;
	} in_item_t;

	typedef struct packed {
		logic        tone_stop;
		logic        tone_start;
		logic [15:0] tone_freq_hz;
		logic [15:0] tone_dur_ms;
		logic        request_dropped;
	} out_item_t;

	typedef struct packed {
		logic        mute;
		logic [15:0] tick_hz;
		logic [15:0] click_hz;
		logic [15:0] fifth_low_hz;
		logic [15:0] fifth_high_hz;
		logic [15:0] siren_low_hz;
		logic [15:0] siren_high_hz;
		logic [15:0] note_ms;
	} cfg_t;

	typedef enum logic {
		KIND_PLAY = 1'b0,
		KIND_TICK = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [2:0]  code;
		logic [31:0] now_ms;
		logic        siren;
	} cmd_t;

endpackage

// ===== rtl/bts_front.sv =====
module bts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bts_pkg::in_item_t in_item,
	output logic              cmd_valid,
	output bts_pkg::cmd_t     cmd,
	input  logic              cmd_pop
);
	import bts_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cmd_new;

	assign in_ready  = (count_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	always_comb begin
		cmd_new.kind   = in_item.opcode ? KIND_TICK : KIND_PLAY;
		cmd_new.code   = in_item.sound_code;
		cmd_new.now_ms = in_item.now_ms;
		cmd_new.siren  = in_item.error_siren;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule

// ===== rtl/bts_back.sv =====
module bts_back #(
	parameter int QUEUE_DEPTH = 8,
	parameter int CLICK_MS    = 20,
	parameter int SIREN_MS    = 400
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bts_pkg::cfg_t      cfg,
	input  logic               cmd_valid,
	input  bts_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output bts_pkg::out_item_t out_item
);
	import bts_pkg::*;

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [15:0] CLICK_DUR = 16'(CLICK_MS);
	localparam logic [15:0] SIREN_DUR = 16'(SIREN_MS);

	// request queue storage, read data registered at the next head
	logic [2:0]    req_mem [QUEUE_DEPTH];
	logic [2:0]    head_rd_q;
	logic [QW-1:0] head_q, head_d, tail_q;
	logic [CW-1:0] count_q;

	logic        seq_q, seq_d;
	logic [2:0]  active_q, active_d;
	logic        idx_q, idx_d;
	logic [31:0] note_start_q, note_start_d;
	logic [31:0] siren_last_q, siren_last_d;
	logic        pitch_q, pitch_d;
	logic        sounding_q, sounding_d;

	logic        out_valid_q;
	out_item_t   out_q;
	out_item_t   res;

	logic        fire;
	logic        push, pop;
	logic        start;
	logic [2:0]  start_code;
	logic        start_idx;
	logic [15:0] start_freq;
	logic [31:0] note_elapsed;
	logic [31:0] siren_elapsed;
	logic        last_note;

	function automatic logic [15:0] note_freq(input cfg_t c, input logic [2:0] code,
		input logic idx);
		logic [15:0] f;
		case (code)
			SOUND_TICK:  f = c.tick_hz;
			SOUND_CLICK: f = c.click_hz;
			SOUND_ENTER: f = idx ? c.fifth_high_hz : c.fifth_low_hz;
			default:     f = idx ? c.fifth_low_hz : c.fifth_high_hz;
		endcase
		return f;
	endfunction

	function automatic logic [15:0] note_dur(input cfg_t c, input logic [2:0] code);
		return (code < SOUND_ENTER) ? CLICK_DUR : c.note_ms;
	endfunction

	assign fire      = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_pop   = fire;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign note_elapsed  = cmd.now_ms - note_start_q;
	assign siren_elapsed = cmd.now_ms - siren_last_q;
	assign last_note     = idx_q || (active_q < SOUND_ENTER);

	always_comb begin
		res          = '0;
		push         = 1'b0;
		pop          = 1'b0;
		start        = 1'b0;
		start_code   = active_q;
		start_idx    = idx_q;
		seq_d        = seq_q;
		active_d     = active_q;
		idx_d        = idx_q;
		note_start_d = note_start_q;
		siren_last_d = siren_last_q;
		pitch_d      = pitch_q;
		sounding_d   = sounding_q;

		if (cmd.kind == KIND_PLAY) begin
			if (count_q == FULL_CNT) begin
				res.request_dropped = 1'b1;
			end else begin
				push = 1'b1;
			end
		end else if (seq_q) begin
			// sequence owns the buzzer until its last note has run out
			if (note_elapsed >= {16'd0, note_dur(cfg, active_q)}) begin
				if (last_note) begin
					seq_d         = 1'b0;
					idx_d         = 1'b0;
					res.tone_stop = 1'b1;
				end else begin
					idx_d     = 1'b1;
					start     = 1'b1;
					start_idx = 1'b1;
				end
			end
		end else if (cmd.siren) begin
			if (siren_elapsed >= {16'd0, SIREN_DUR}) begin
				pitch_d      = ~pitch_q;
				siren_last_d = cmd.now_ms;
				if (!cfg.mute) begin
					res.tone_start   = 1'b1;
					res.tone_freq_hz = pitch_q ? cfg.siren_low_hz : cfg.siren_high_hz;
					res.tone_dur_ms  = SIREN_DUR;
				end
			end
			sounding_d = 1'b1;
		end else begin
			if (sounding_q) begin
				res.tone_stop = 1'b1;
				sounding_d    = 1'b0;
			end
			if (count_q != '0) begin
				pop = 1'b1;
				// silent codes are dropped here
				if (head_rd_q <= SOUND_EXIT) begin
					active_d   = head_rd_q;
					idx_d      = 1'b0;
					seq_d      = 1'b1;
					start      = 1'b1;
					start_code = head_rd_q;
					start_idx  = 1'b0;
				end
			end
		end

		start_freq = note_freq(cfg, start_code, start_idx);
		if (start) begin
			note_start_d = cmd.now_ms;
			if (!cfg.mute && start_freq != 16'd0) begin
				res.tone_start   = 1'b1;
				res.tone_freq_hz = start_freq;
				res.tone_dur_ms  = note_dur(cfg, start_code);
			end
		end
	end

	always_comb begin
		head_d = head_q;
		if (fire && pop) begin
			head_d = (head_q == LAST_IDX) ? '0 : head_q + QW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && push) begin
			req_mem[tail_q] <= cmd.code;
		end
		if (fire && push && tail_q == head_d) begin
			head_rd_q <= cmd.code;
		end else begin
			head_rd_q <= req_mem[head_d];
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			seq_q        <= 1'b0;
			active_q     <= '0;
			idx_q        <= 1'b0;
			note_start_q <= '0;
			siren_last_q <= '0;
			pitch_q      <= 1'b0;
			sounding_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			head_q <= head_d;
			if (fire) begin
				if (push) begin
					tail_q  <= (tail_q == LAST_IDX) ? '0 : tail_q + QW'(1);
					count_q <= count_q + CW'(1);
				end
				if (pop) begin
					count_q <= count_q - CW'(1);
				end
				seq_q        <= seq_d;
				active_q     <= active_d;
				idx_q        <= idx_d;
				note_start_q <= note_start_d;
				siren_last_q <= siren_last_d;
				pitch_q      <= pitch_d;
				sounding_q   <= sounding_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("request queue count above depth");

	assert property (@(posedge clk) disable iff (!arst_n) seq_q |-> !sounding_q)
		else $error("sequence running while siren still sounding");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.request_dropped |-> !out_q.tone_start && !out_q.tone_stop)
		else $error("dropped request carries a tone command");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.tone_start |-> out_q.tone_freq_hz == 16'd0
			&& out_q.tone_dur_ms == 16'd0)
		else $error("tone fields set without a start");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && pop |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not lower the queue count");

endmodule

// ===== rtl/buzzer_tone_sequencer.sv =====
// Buzzer tone sequencer: play items queue a sound code (up to QUEUE_DEPTH waiting, a full
// queue reports request_dropped), tick items run the note sequence, the error siren and the
// queue, and every item yields exactly one result item. One item is accepted per clock while
// the front queue has room; accepted items pass a two-entry front queue and are carried out
// by a back stage that does one item per cycle into an output register while that register
// is empty or out_ready takes its result, so the back stage and out_ready set the rate.
// A result is registered once its item leaves the front queue. There is no clearing pass
// after reset. Configuration writes take effect at once and belong to idle periods.
module buzzer_tone_sequencer #(
	parameter int QUEUE_DEPTH = 8,
	parameter int CLICK_MS    = 20,
	parameter int SIREN_MS    = 400
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bts_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output bts_pkg::out_item_t               out_item,
	input  logic                             cfg_we,
	input  logic [bts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import bts_pkg::*;

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mute          <= 1'b0;
			cfg_q.tick_hz       <= 16'd4000;
			cfg_q.click_hz      <= 16'd2000;
			cfg_q.fifth_low_hz  <= 16'd880;
			cfg_q.fifth_high_hz <= 16'd1320;
			cfg_q.siren_low_hz  <= 16'd600;
			cfg_q.siren_high_hz <= 16'd1000;
			cfg_q.note_ms       <= 16'd120;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MUTE:          cfg_q.mute          <= cfg_wdata[0];
				CFG_TICK_HZ:       cfg_q.tick_hz       <= cfg_wdata;
				CFG_CLICK_HZ:      cfg_q.click_hz      <= cfg_wdata;
				CFG_FIFTH_LOW_HZ:  cfg_q.fifth_low_hz  <= cfg_wdata;
				CFG_FIFTH_HIGH_HZ: cfg_q.fifth_high_hz <= cfg_wdata;
				CFG_SIREN_LOW_HZ:  cfg_q.siren_low_hz  <= cfg_wdata;
				CFG_SIREN_HIGH_HZ: cfg_q.siren_high_hz <= cfg_wdata;
				CFG_NOTE_MS:       cfg_q.note_ms       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	bts_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CLICK_MS    (CLICK_MS),
		.SIREN_MS    (SIREN_MS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
